// ===== sv/pkfwl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkfwl_pkg
// Shared types and constants of the per-key fixed-window limiter.
// ----------------------------------------------------------------------------
package pkfwl_pkg;

  localparam int CAP_W  = 16;
  localparam int WIN_W  = 32;
  localparam int TIME_W = 48;
  localparam int CNT_W  = 11;

  localparam logic [1:0] KIND_CHECK  = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_SWEEP  = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  localparam logic CFG_CAP    = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  localparam logic [63:0] HASH_K0 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_K1 = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] HASH_K2 = 64'hC4CEB9FE1A85EC53;

  typedef struct packed {
    logic [1:0]        kind;
    logic [63:0]       user_key;
    logic [31:0]       campaign;
    logic [TIME_W-1:0] now_time;
  } op_t;

  typedef struct packed {
    logic              valid;
    logic [63:0]       user_key;
    logic [31:0]       campaign;
    logic [TIME_W-1:0] start;
    logic [CAP_W-1:0]  count;
  } row_t;

endpackage

// ===== sv/pkfwl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkfwl_req_if / pkfwl_rsp_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface pkfwl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] user_key;
  logic [31:0] campaign;
  logic [47:0] now_time;
  modport source (output valid, kind, user_key, campaign, now_time, input ready);
  modport sink (input valid, kind, user_key, campaign, now_time, output ready);
endinterface

interface pkfwl_rsp_if;
  logic        valid;
  logic        ready;
  logic        permitted;
  logic        status;
  logic [10:0] removed_count;
  logic [10:0] live_entries;
  modport source (output valid, permitted, status, removed_count, live_entries,
                  input ready);
  modport sink (input valid, permitted, status, removed_count, live_entries,
                output ready);
endinterface

// ===== sv/pkfwl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkfwl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pkfwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pkfwl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkfwl_queue
// Two-entry FIFO between the hashing front end and the table engine.
// ----------------------------------------------------------------------------
module pkfwl_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/pkfwl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkfwl_front
// Accepts request words, hashes the key with a shared 32x32 multiplier,
// reduces the hash to a slot by byte folding and a reciprocal multiply,
// then queues the word.
// ----------------------------------------------------------------------------
module pkfwl_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           hold,
  pkfwl_req_if.sink                      req,
  output logic                           q_push,
  input  logic                           q_full,
  output pkfwl_pkg::op_t                 q_op,
  output logic [$clog2(TABLE_DEPTH)-1:0] q_slot
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int RW   = AW + 1;
  localparam int FS_W = RW + 11;
  localparam int MW   = FS_W + 1;
  localparam int KSH  = FS_W + AW;
  localparam int QTW  = MW - AW;
  localparam logic [RW-1:0] DIVC = RW'(TABLE_DEPTH);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << KSH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

  typedef logic [7:0][RW-1:0] fold_tab_t;

  function automatic fold_tab_t fold_table();
    fold_tab_t   t;
    logic [63:0] p;
    for (int j = 0; j < 8; j++) begin
      p = (64'd1 << (8 * j)) % 64'(TABLE_DEPTH);
      t[j] = p[RW-1:0];
    end
    return t;
  endfunction

  localparam fold_tab_t FOLD_K = fold_table();

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_MOD, F_QUO, F_REM, F_PUSH} fstate_t;

  fstate_t        state;
  pkfwl_pkg::op_t op;
  logic [63:0]    mul_a;
  logic [1:0]     sel;
  logic [1:0]     phase;
  logic [63:0]    acc;
  logic [63:0]    modv;
  logic [FS_W-1:0] fsum;
  logic [QTW-1:0] quo;
  logic [AW-1:0]  rem;
  logic [2:0]     mcnt;

  logic [63:0] kb;
  logic [31:0] mx, my;
  logic [63:0] prod;
  logic [63:0] acc_next;
  logic [63:0] mixed;
  logic [63:0] v2;

  logic [RW+7:0]       fprod;
  logic [FS_W-1:0]     fsum_next;
  logic [FS_W+MW-1:0]  qprod;
  logic [QTW+RW-1:0]   qd;
  logic [FS_W-1:0]     rem_full;

  always_comb begin
    case (sel)
      2'd0:    kb = pkfwl_pkg::HASH_K0;
      2'd1:    kb = pkfwl_pkg::HASH_K1;
      default: kb = pkfwl_pkg::HASH_K2;
    endcase
    case (phase)
      2'd0:    begin mx = mul_a[31:0];  my = kb[31:0];  end
      2'd1:    begin mx = mul_a[31:0];  my = kb[63:32]; end
      default: begin mx = mul_a[63:32]; my = kb[31:0];  end
    endcase
    prod = {32'b0, mx} * {32'b0, my};
    if (phase == 2'd0) acc_next = prod;
    else acc_next = acc + {prod[31:0], 32'b0};
    mixed = (sel == 2'd0) ? (op.user_key ^ acc_next) : acc_next;
    v2 = mixed ^ (mixed >> 33);
  end

  // fold one byte per cycle with weight 2^(8j) mod depth; the small sum then
  // takes an exact reciprocal quotient and one multiply-subtract
  always_comb begin
    fprod     = modv[7:0] * FOLD_K[mcnt];
    fsum_next = fsum + FS_W'(fprod);
    qprod     = fsum * RECIP;
    qd        = quo * DIVC;
    rem_full  = fsum - qd[FS_W-1:0];
  end

  assign req.ready = (state == F_IDLE) && !hold;
  assign q_push    = (state == F_PUSH) && !q_full;
  assign q_op      = op;
  assign q_slot    = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.valid && req.ready) begin
            op.kind     <= req.kind;
            op.user_key <= req.user_key;
            op.campaign <= req.campaign;
            op.now_time <= req.now_time;
            mul_a <= {32'b0, req.campaign};
            sel   <= 2'd0;
            phase <= 2'd0;
            rem   <= '0;
            if (req.kind == pkfwl_pkg::KIND_CHECK || req.kind == pkfwl_pkg::KIND_RECORD)
              state <= F_MUL;
            else
              state <= F_PUSH;
          end
        end
        F_MUL: begin
          acc <= acc_next;
          if (phase == 2'd2) begin
            phase <= 2'd0;
            if (sel == 2'd2) begin
              modv  <= v2;
              mcnt  <= 3'd0;
              fsum  <= '0;
              state <= F_MOD;
            end else begin
              mul_a <= v2;
              sel   <= sel + 2'd1;
            end
          end else begin
            phase <= phase + 2'd1;
          end
        end
        F_MOD: begin
          fsum <= fsum_next;
          modv <= modv >> 8;
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd7) state <= F_QUO;
        end
        F_QUO: begin
          quo   <= qprod[FS_W+MW-1:KSH];
          state <= F_REM;
        end
        F_REM: begin
          rem   <= rem_full[AW-1:0];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/pkfwl_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkfwl_engine
// Table engine: clears the slot table after reset, runs check/record
// read-modify-writes and expiry sweeps, and holds the result register.
// ----------------------------------------------------------------------------
module pkfwl_engine #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  output logic                             clearing,
  input  logic                             q_empty,
  output logic                             q_pop,
  input  pkfwl_pkg::op_t                   q_op,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   q_slot,
  input  logic [pkfwl_pkg::CAP_W-1:0]      cap,
  input  logic [pkfwl_pkg::WIN_W-1:0]      win,
  pkfwl_rsp_if.source                      rsp
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = pkfwl_pkg::CNT_W;
  localparam int TW    = pkfwl_pkg::TIME_W;
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {E_CLEAR, E_IDLE, E_EXEC, E_SWEEP, E_SDONE} estate_t;

  function automatic logic expired(input logic [TW-1:0] start, input logic [TW-1:0] now,
                                   input logic [pkfwl_pkg::WIN_W-1:0] wl);
    logic [TW:0] diff;
    diff = {1'b0, now} - {1'b0, start};
    return (wl == '0) || (!diff[TW] && (diff[TW-1:0] >= {{(TW-pkfwl_pkg::WIN_W){1'b0}}, wl}));
  endfunction

  estate_t          state;
  pkfwl_pkg::op_t   cur;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    chk;
  logic             chk_v;
  logic             rd_on;
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] removed;
  logic             out_valid;
  logic             out_perm;
  logic             out_stat;
  logic [CW-1:0]    out_rem;
  logic [CW-1:0]    out_live;

  logic             re, we;
  logic [AW-1:0]    raddr, waddr;
  pkfwl_pkg::row_t  wdata, row;

  pkfwl_ram #(.WIDTH($bits(pkfwl_pkg::row_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(row)
  );

  logic                       same, exp, collide, fresh, under, chk_perm, out_free;
  logic                       sweep_hit, is_rec, out_load;
  logic [pkfwl_pkg::CAP_W-1:0] base_count;
  logic [OCC_W-1:0]           occ_exec, occ_swept;
  logic [OCC_W+CW-1:0]        live_ext, swept_ext, rem_ext;

  always_comb begin
    same     = row.valid && (row.user_key == cur.user_key) && (row.campaign == cur.campaign);
    exp      = row.valid && expired(row.start, cur.now_time, win);
    collide  = row.valid && !same && !exp;
    fresh    = !same || (row.count == '0) || exp;
    base_count = fresh ? '0 : row.count;
    under    = base_count < cap;
    chk_perm = (!same || exp) ? 1'b1 : (row.count < cap);
    out_free = !out_valid || rsp.ready;
    out_load = out_free && ((state == E_EXEC) || (state == E_SDONE));
    is_rec   = (cur.kind == pkfwl_pkg::KIND_RECORD);
    sweep_hit = chk_v && row.valid && expired(row.start, cur.now_time, win);
    occ_exec = occ + OCC_W'(is_rec && !collide && !row.valid);
    occ_swept = occ - removed;
    live_ext  = {{CW{1'b0}}, occ_exec};
    swept_ext = {{CW{1'b0}}, occ_swept};
    rem_ext   = {{CW{1'b0}}, removed};
  end

  always_comb begin
    re    = 1'b0;
    raddr = addr;
    we    = 1'b0;
    waddr = chk;
    wdata = row;
    q_pop = 1'b0;
    unique case (state)
      E_CLEAR: begin
        we    = 1'b1;
        waddr = addr;
        wdata = '0;
      end
      E_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          re    = 1'b1;
          raddr = (q_op.kind == pkfwl_pkg::KIND_SWEEP) ? '0 : q_slot;
        end
      end
      E_EXEC: begin
        if (out_free && is_rec && !collide) begin
          we             = 1'b1;
          waddr          = addr;
          wdata.valid    = 1'b1;
          wdata.user_key = cur.user_key;
          wdata.campaign = cur.campaign;
          wdata.start    = fresh ? cur.now_time : row.start;
          wdata.count    = base_count + pkfwl_pkg::CAP_W'(under);
        end
      end
      E_SWEEP: begin
        re = rd_on;
        if (sweep_hit) begin
          we          = 1'b1;
          wdata.valid = 1'b0;
        end
      end
      E_SDONE: begin
      end
      default: begin
      end
    endcase
  end

  assign clearing          = (state == E_CLEAR);
  assign rsp.valid         = out_valid;
  assign rsp.permitted     = out_perm;
  assign rsp.status        = out_stat;
  assign rsp.removed_count = out_rem;
  assign rsp.live_entries  = out_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_CLEAR;
      addr      <= '0;
      chk_v     <= 1'b0;
      rd_on     <= 1'b0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        E_CLEAR: begin
          if (addr == LAST) begin
            addr  <= '0;
            state <= E_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        E_IDLE: begin
          if (!q_empty) begin
            cur <= q_op;
            if (q_op.kind == pkfwl_pkg::KIND_SWEEP) begin
              addr    <= AW'(1);
              chk     <= '0;
              chk_v   <= 1'b1;
              rd_on   <= 1'b1;
              removed <= '0;
              state   <= E_SWEEP;
            end else begin
              addr  <= q_slot;
              state <= E_EXEC;
            end
          end
        end
        E_EXEC: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_rem   <= '0;
            out_live  <= live_ext[CW-1:0];
            case (cur.kind)
              pkfwl_pkg::KIND_CHECK: begin
                out_stat <= collide;
                out_perm <= !collide && chk_perm;
              end
              pkfwl_pkg::KIND_RECORD: begin
                out_stat <= collide;
                out_perm <= !collide && under;
                occ      <= occ_exec;
              end
              default: begin
                out_stat <= 1'b0;
                out_perm <= 1'b0;
              end
            endcase
            state <= E_IDLE;
          end
        end
        E_SWEEP: begin
          if (sweep_hit) removed <= removed + OCC_W'(1);
          if (rd_on) begin
            chk   <= addr;
            chk_v <= 1'b1;
            if (addr == LAST) rd_on <= 1'b0;
            else addr <= addr + AW'(1);
          end else begin
            chk_v <= 1'b0;
            state <= E_SDONE;
          end
        end
        E_SDONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_perm  <= 1'b0;
            out_stat  <= 1'b0;
            out_rem   <= rem_ext[CW-1:0];
            out_live  <= swept_ext[CW-1:0];
            occ       <= occ_swept;
            state     <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/per_key_fixed_window_limiter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_fixed_window_limiter_top
// Per-key fixed-window impression limiter on a direct-mapped slot table.
//
// channel  dir  handshake        word
// req      in   valid/ready      kind, user_key, campaign, now_time
// rsp      out  valid/ready      permitted, status, removed_count, live_entries
// cfg      in   cfg_we           cfg_index, cfg_data (write only)
//
// Check/record: the front end accepts, runs nine 32x32 multiply passes for
// the key hash, eight byte-fold steps, quotient, remainder and one queue
// push; the engine then does a slot read-modify-write.
// A sweep walks every slot in the engine.
// After reset a clearing pass over every slot runs; req.ready is low.
// A two-entry queue lets the front end hash while the engine or rsp stalls.
// ----------------------------------------------------------------------------
module per_key_fixed_window_limiter_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  pkfwl_req_if.sink   req,
  pkfwl_rsp_if.source rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int QW = $bits(pkfwl_pkg::op_t) + AW;

  logic [pkfwl_pkg::CAP_W-1:0] cap;
  logic [pkfwl_pkg::WIN_W-1:0] win;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= pkfwl_pkg::CAP_W'(3);
      win <= pkfwl_pkg::WIN_W'(60000);
    end else if (cfg_we) begin
      if (cfg_index == pkfwl_pkg::CFG_CAP) cap <= cfg_data[pkfwl_pkg::CAP_W-1:0];
      else win <= cfg_data[pkfwl_pkg::WIN_W-1:0];
    end
  end

  logic           clearing;
  logic           f_push, q_full, q_empty, q_pop;
  pkfwl_pkg::op_t f_op, e_op;
  logic [AW-1:0]  f_slot, e_slot;
  logic [QW-1:0]  q_dout;

  pkfwl_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .hold(clearing), .req(req),
    .q_push(f_push), .q_full(q_full), .q_op(f_op), .q_slot(f_slot)
  );

  pkfwl_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst), .push(f_push), .din({f_op, f_slot}), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  assign e_op   = q_dout[QW-1:AW];
  assign e_slot = q_dout[AW-1:0];

  pkfwl_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk(clk), .rst(rst), .clearing(clearing),
    .q_empty(q_empty), .q_pop(q_pop), .q_op(e_op), .q_slot(e_slot),
    .cap(cap), .win(win), .rsp(rsp)
  );

endmodule
